// ===== hdl/ect_pkg.sv =====
// ----------------------------------------------------------------------------
// ect_pkg
// Types and constants shared by the exposure compensated trigger block.
// ----------------------------------------------------------------------------
package ect_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 26;
  localparam int unsigned ExpW     = 24;
  localparam int unsigned TpsW     = 26;
  localparam int unsigned CmpW     = 16;
  localparam int unsigned ImgW     = 32;
  localparam int unsigned ProdW    = ExpW + TpsW;

  // us * ticks / 2000000 = ((us * ticks) >> 7) / 15625
  localparam int unsigned DivShift = 7;
  localparam int unsigned QuotW    = 30;
  localparam int unsigned RecipW   = 31;
  localparam int unsigned RecipSh  = 44;
  localparam logic [RecipW-1:0] RecipM = 31'd1125899907;
  localparam int unsigned SatBits  = 37;
  localparam logic [SatBits-1:0] SatLimit = 37'd131072000000;

  typedef enum logic [1:0] {
    CMD_TIMER    = 2'd0,
    CMD_EXP_END  = 2'd1,
    CMD_INIT_MSG = 2'd2,
    CMD_INIT_REQ = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_EN   = 3'd0,
    CFG_COMP_EN    = 3'd1,
    CFG_MAX_EXP    = 3'd2,
    CFG_PERIOD_CMP = 3'd3,
    CFG_TICKS_PS   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CV_NONE   = 2'd0,
    CV_PERIOD = 2'd1,
    CV_DELAY  = 2'd2,
    CV_NEW    = 2'd3
  } cv_op_e;

  typedef struct packed {
    logic [1:0]      cmd;
    logic            overflow_seen;
    logic [ExpW-1:0] exposure_us;
    logic            init_value;
  } in_item_t;

  typedef struct packed {
    logic            trigger_pulse;
    logic            long_pulse;
    logic            timestamp_strobe;
    logic [ImgW-1:0] image_count;
    logic            compare_write;
    logic [CmpW-1:0] compare_value;
    logic            clear_overflow;
    logic            compensating_now;
  } out_item_t;

  typedef struct packed {
    logic            trig;
    logic            longp;
    logic            strobe;
    logic            clr;
    logic            comp_now;
    logic            exp_ok;
    cv_op_e          op;
    logic [ImgW-1:0] image;
  } ctl_t;

endpackage

// ===== hdl/exposure_compensated_trigger.sv =====
// ----------------------------------------------------------------------------
// exposure_compensated_trigger
// Sensor trigger controller with mid-exposure timestamping and exposure
// time compensation of the timer compare value.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o/in_item_i) takes one event per item:
//   timer interrupt, exposure end, init message or initialize request.
//   out channel (out_valid_o/out_ready_i/out_item_o) returns one result item
//   per event, in order.
//   cfg channel (cfg_valid_i/cfg_index_i/cfg_data_i), always ready, writes a
//   register; the user writes only while no event is in flight (unenforced).
// Pipeline:
//   a product register (exposure times tick rate), a reciprocal product
//   register (division by 2000000) and the result register lie between accept
//   and result valid. One item per cycle sustained while out_ready_i is high.
// Reset:
//   control and config registers return to their defaults, the pipeline
//   empties, the image count is zero and the block is uninitialized.
// Stall:
//   while out_ready_i is low the result holds, the pipeline fills, and
//   in_ready_o drops once all three stages are occupied.
// ----------------------------------------------------------------------------
module exposure_compensated_trigger (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ect_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ect_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ect_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ect_pkg::out_item_t              out_item_o
);
  import ect_pkg::*;

  logic                 blk_en_q;
  logic                 comp_en_q;
  logic [ExpW-1:0]      max_exp_q;
  logic [CmpW-1:0]      period_q;
  logic [TpsW-1:0]      tps_q;

  logic                 init_q, init_d;
  logic                 comp_q, comp_d;
  logic                 exp_q, exp_d;
  logic [ImgW-1:0]      img_q, img_d;
  logic [CmpW-1:0]      delay_q;

  logic                 s1_valid_q, s2_valid_q, out_valid_q;
  ctl_t                 ctl_d, s1_ctl_q, s2_ctl_q;
  logic [ProdW-1:0]     s1_p_q;
  logic [CmpW-1:0]      s2_quot_q;
  logic                 s2_sat_q;
  out_item_t            out_q, out_d;

  logic                 in_acc, s1_adv, s2_adv, out_free;
  logic                 sat_d;
  logic [QuotW-1:0]     y;
  logic [QuotW+RecipW-1:0] recip_prod;
  logic [CmpW-1:0]      new_delay, cval;
  logic                 delay_upd;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign s2_adv      = s2_valid_q && out_free;
  assign s1_adv      = s1_valid_q && (!s2_valid_q || s2_adv);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;

  // event decode
  always_comb begin
    init_d = init_q;
    comp_d = comp_q;
    exp_d  = exp_q;
    img_d  = img_q;
    ctl_d  = '0;
    ctl_d.op = CV_NONE;
    if (blk_en_q) begin
      unique case (cmd_e'(in_item_i.cmd))
        CMD_TIMER: begin
          if (in_item_i.overflow_seen && init_q) begin
            ctl_d.clr = 1'b1;
            if (comp_en_q && comp_q) begin
              if (!exp_q) begin
                exp_d     = 1'b1;
                ctl_d.trig = 1'b1;
                img_d     = img_q + 1'b1;
                ctl_d.op  = CV_DELAY;
              end else begin
                ctl_d.strobe = 1'b1;
                comp_d       = 1'b0;
                ctl_d.op     = CV_PERIOD;
              end
            end else begin
              exp_d        = 1'b1;
              ctl_d.trig   = 1'b1;
              ctl_d.strobe = 1'b1;
              img_d        = img_q + 1'b1;
              ctl_d.op     = CV_PERIOD;
            end
          end
        end
        CMD_EXP_END: begin
          if (comp_en_q) begin
            ctl_d.exp_ok = (in_item_i.exposure_us != '0) &&
                           (in_item_i.exposure_us < max_exp_q);
            comp_d   = ctl_d.exp_ok;
            exp_d    = 1'b0;
            ctl_d.op = CV_NEW;
          end
        end
        CMD_INIT_MSG: begin
          init_d = in_item_i.init_value;
        end
        CMD_INIT_REQ: begin
          if (!init_q) begin
            ctl_d.trig   = 1'b1;
            ctl_d.longp  = 1'b1;
            ctl_d.strobe = 1'b1;
            img_d        = img_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    ctl_d.comp_now = comp_d;
    ctl_d.image    = img_d;
  end

  // constant division by reciprocal multiply, saturated at full scale
  assign sat_d      = (|s1_p_q[ProdW-1:SatBits]) || (s1_p_q[SatBits-1:0] >= SatLimit);
  assign y          = s1_p_q[SatBits-1:DivShift];
  assign recip_prod = (QuotW+RecipW)'(y) * (QuotW+RecipW)'(RecipM);

  // result assembly
  always_comb begin
    new_delay = '0;
    if (s2_ctl_q.exp_ok) begin
      new_delay = s2_sat_q ? {CmpW{1'b1}} : s2_quot_q;
    end
    delay_upd = s2_adv && (s2_ctl_q.op == CV_NEW);
    unique case (s2_ctl_q.op)
      CV_NONE:   cval = '0;
      CV_PERIOD: cval = period_q;
      CV_DELAY:  cval = (delay_q != '0) ? delay_q - 1'b1 : period_q;
      CV_NEW:    cval = (period_q > new_delay) ? period_q - new_delay : '0;
      default:   cval = '0;
    endcase
    out_d.trigger_pulse    = s2_ctl_q.trig;
    out_d.long_pulse       = s2_ctl_q.longp;
    out_d.timestamp_strobe = s2_ctl_q.strobe;
    out_d.image_count      = s2_ctl_q.image;
    out_d.compare_write    = (s2_ctl_q.op != CV_NONE);
    out_d.compare_value    = cval;
    out_d.clear_overflow   = s2_ctl_q.clr;
    out_d.compensating_now = s2_ctl_q.comp_now;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_en_q    <= 1'b1;
      comp_en_q   <= 1'b1;
      max_exp_q   <= 24'd9900;
      period_q    <= 16'd60000;
      tps_q       <= 26'd187500;
      init_q      <= 1'b0;
      comp_q      <= 1'b0;
      exp_q       <= 1'b0;
      img_q       <= '0;
      delay_q     <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_BLOCK_EN:   blk_en_q  <= cfg_data_i[0];
          CFG_COMP_EN:    comp_en_q <= cfg_data_i[0];
          CFG_MAX_EXP:    max_exp_q <= cfg_data_i[ExpW-1:0];
          CFG_PERIOD_CMP: period_q  <= cfg_data_i[CmpW-1:0];
          CFG_TICKS_PS:   tps_q     <= cfg_data_i[TpsW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        init_q <= init_d;
        comp_q <= comp_d;
        exp_q  <= exp_d;
        img_q  <= img_d;
      end
      if (delay_upd) begin
        delay_q <= new_delay;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (!s2_valid_q || s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ctl_q <= ctl_d;
      s1_p_q   <= ProdW'(in_item_i.exposure_us) * ProdW'(tps_q);
    end
    if (s1_adv) begin
      s2_ctl_q  <= s1_ctl_q;
      s2_sat_q  <= sat_d;
      s2_quot_q <= recip_prod[RecipSh+CmpW-1:RecipSh];
    end
    if (s2_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_cval_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.compare_write || out_item_o.compare_value == '0))
    else $error("compare value without compare write");

  a_long_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.long_pulse |->
      out_item_o.trigger_pulse && out_item_o.timestamp_strobe && !out_item_o.compare_write)
    else $error("long pulse without trigger and strobe");

  a_clear_has_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.clear_overflow |-> out_item_o.compare_write)
    else $error("overflow cleared without compare write");

  a_s2_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_free |=> s2_valid_q && $stable(s2_ctl_q))
    else $error("stage two item lost during stall");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted item not in stage one");
`endif

endmodule

// ===== dv/tb_exposure_compensated_trigger.sv =====
// ----------------------------------------------------------------------------
// tb_exposure_compensated_trigger
// Self-checking bench for the exposure compensated trigger. A scoreboard
// predicts each result item from the accepted event and its own copy of the
// trigger state. Traffic starts with directed events and register settings,
// then runs random phases of exposure/trigger sequences mixed with noise
// under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_exposure_compensated_trigger;
  timeunit 1ns;
  timeprecision 1ps;

  import ect_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_item_o;

  exposure_compensated_trigger dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  in_item_t  event_q[$];
  out_item_t expected_results[$];
  int        error_count = 0;
  int        n_queued    = 0;
  int        n_checked   = 0;

  // register copies
  logic            m_block_en;
  logic            m_comp_en;
  logic [ExpW-1:0] m_max_exp;
  logic [CmpW-1:0] m_period;
  logic [TpsW-1:0] m_tps;

  // trigger state copies
  logic            st_init;
  logic            st_comp;
  logic            st_exposing;
  logic [ImgW-1:0] st_image;
  logic [CmpW-1:0] st_delay;

  function automatic out_item_t predict_trigger_result(in_item_t ev);
    out_item_t   r;
    logic [63:0] ticks;
    r = '0;
    if (m_block_en) begin
      case (ev.cmd)
        CMD_TIMER: begin
          if (ev.overflow_seen && st_init) begin
            if (m_comp_en && st_comp) begin
              if (!st_exposing) begin
                st_exposing     = 1'b1;
                r.trigger_pulse = 1'b1;
                st_image        = st_image + 32'd1;
                r.compare_write = 1'b1;
                r.compare_value = (st_delay != '0) ? st_delay - 16'd1 : m_period;
              end else begin
                r.timestamp_strobe = 1'b1;
                st_comp            = 1'b0;
                r.compare_write    = 1'b1;
                r.compare_value    = m_period;
              end
            end else begin
              st_exposing        = 1'b1;
              r.trigger_pulse    = 1'b1;
              r.timestamp_strobe = 1'b1;
              st_image           = st_image + 32'd1;
              r.compare_write    = 1'b1;
              r.compare_value    = m_period;
            end
            r.clear_overflow = 1'b1;
          end
        end
        CMD_EXP_END: begin
          if (m_comp_en) begin
            if (ev.exposure_us == '0 || ev.exposure_us >= m_max_exp) begin
              st_delay = '0;
              st_comp  = 1'b0;
            end else begin
              ticks    = (64'(ev.exposure_us) * 64'(m_tps)) / 64'd2000000;
              st_delay = (ticks > 64'd65535) ? 16'hFFFF : ticks[15:0];
              st_comp  = 1'b1;
            end
            r.compare_write = 1'b1;
            r.compare_value = (m_period > st_delay) ? m_period - st_delay : '0;
            st_exposing     = 1'b0;
          end
        end
        CMD_INIT_MSG: begin
          st_init = ev.init_value;
        end
        default: begin
          if (!st_init) begin
            r.trigger_pulse    = 1'b1;
            r.long_pulse       = 1'b1;
            r.timestamp_strobe = 1'b1;
            st_image           = st_image + 32'd1;
          end
        end
      endcase
    end
    r.image_count      = st_image;
    r.compensating_now = st_comp;
    return r;
  endfunction

  function automatic void queue_event(cmd_e c, logic ovf, logic [ExpW-1:0] us, logic iv);
    in_item_t ev;
    ev.cmd           = c;
    ev.overflow_seen = ovf;
    ev.exposure_us   = us;
    ev.init_value    = iv;
    event_q.push_back(ev);
    n_queued++;
  endfunction

  function automatic logic [ExpW-1:0] pick_exposure();
    if (m_max_exp > 24'd1 && $urandom_range(0, 1) == 1)
      return ExpW'($urandom_range(1, 32'(m_max_exp) - 1));
    return ExpW'($urandom() >> $urandom_range(8, 31));
  endfunction

  // one random sequence; returns the number of events queued
  function automatic int queue_random_sequence();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      queue_event(CMD_EXP_END, 1'($urandom_range(0, 1)), pick_exposure(), 1'($urandom_range(0, 1)));
      queue_event(CMD_TIMER, 1'b1, ExpW'($urandom()), 1'($urandom_range(0, 1)));
      queue_event(CMD_TIMER, 1'b1, ExpW'($urandom()), 1'($urandom_range(0, 1)));
      return 3;
    end
    if (kind == 6) begin
      queue_event(CMD_EXP_END, 1'b0,
                  ($urandom_range(0, 1) == 1) ? '0 : ExpW'($urandom_range(32'(m_max_exp), 24'hFFFFFF)),
                  1'b0);
      queue_event(CMD_TIMER, 1'b1, '0, 1'b0);
      return 2;
    end
    if (kind == 7) begin
      if ($urandom_range(0, 1) == 1)
        queue_event(CMD_INIT_MSG, 1'($urandom_range(0, 1)), ExpW'($urandom()),
                    1'($urandom_range(0, 3) != 0));
      else
        queue_event(CMD_INIT_REQ, 1'($urandom_range(0, 1)), ExpW'($urandom()),
                    1'($urandom_range(0, 1)));
      return 1;
    end
    queue_event(cmd_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), ExpW'($urandom()),
                1'($urandom_range(0, 1)));
    return 1;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_BLOCK_EN:   m_block_en = val[0];
      CFG_COMP_EN:    m_comp_en  = val[0];
      CFG_MAX_EXP:    m_max_exp  = val[ExpW-1:0];
      CFG_PERIOD_CMP: m_period   = val[CmpW-1:0];
      CFG_TICKS_PS:   m_tps      = val[TpsW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic en, logic comp, logic [ExpW-1:0] max_us,
                               logic [CmpW-1:0] period, logic [TpsW-1:0] tps);
    write_reg(CFG_BLOCK_EN, CfgDataW'(en));
    write_reg(CFG_COMP_EN, CfgDataW'(comp));
    write_reg(CFG_MAX_EXP, CfgDataW'(max_us));
    write_reg(CFG_PERIOD_CMP, CfgDataW'(period));
    write_reg(CFG_TICKS_PS, CfgDataW'(tps));
  endtask

  // idle once every queued item has come back as a result
  task automatic wait_until_idle();
    while (n_checked < n_queued)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // sender: bursts with random gaps
  int gap_left   = 0;
  int burst_left = 1;

  always @(posedge clk_i) begin : drive_events
    logic     nxt_valid;
    in_item_t nxt_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_item  = in_item_i;
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_trigger_result(in_item_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (event_q.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_item  = event_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(40, 80);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(0, 6);
          end
        end
      end
      in_valid_i <= nxt_valid;
      in_item_i  <= nxt_item;
    end
  end

  task automatic note_mismatch(string fld, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= 100)
      $display("%0t: %s expected %0h actual %0h", $realtime, fld, want, got);
  endtask

  task automatic check_result(out_item_t want, out_item_t got);
    if (got.trigger_pulse != want.trigger_pulse)
      note_mismatch("trigger_pulse", 32'(want.trigger_pulse), 32'(got.trigger_pulse));
    if (got.long_pulse != want.long_pulse)
      note_mismatch("long_pulse", 32'(want.long_pulse), 32'(got.long_pulse));
    if (got.timestamp_strobe != want.timestamp_strobe)
      note_mismatch("timestamp_strobe", 32'(want.timestamp_strobe), 32'(got.timestamp_strobe));
    if (got.image_count != want.image_count)
      note_mismatch("image_count", want.image_count, got.image_count);
    if (got.compare_write != want.compare_write)
      note_mismatch("compare_write", 32'(want.compare_write), 32'(got.compare_write));
    if (got.compare_value != want.compare_value)
      note_mismatch("compare_value", 32'(want.compare_value), 32'(got.compare_value));
    if (got.clear_overflow != want.clear_overflow)
      note_mismatch("clear_overflow", 32'(want.clear_overflow), 32'(got.clear_overflow));
    if (got.compensating_now != want.compensating_now)
      note_mismatch("compensating_now", 32'(want.compensating_now), 32'(got.compensating_now));
  endtask

  // receiver: rotating ready pattern, re-picked now and then
  logic [7:0] ready_pat = 8'hFF;
  int         pat_age   = 0;

  always @(posedge clk_i) begin : watch_results
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected item, expected none actual %0h", $realtime, out_item_o);
        end else begin
          want = expected_results.pop_front();
          check_result(want, out_item_o);
          n_checked++;
        end
      end
      if (pat_age >= 48) begin
        pat_age   = 0;
        ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
      end else begin
        pat_age++;
        ready_pat = {ready_pat[0], ready_pat[7:1]};
      end
      out_ready_i <= ready_pat[0];
    end
  end

  initial begin
    #2_000_000;
    $display("tb_exposure_compensated_trigger: done, errors");
    $finish;
  end

  initial begin : stimulus
    int count;
    logic            en, comp;
    logic [ExpW-1:0] max_us;
    logic [CmpW-1:0] period;
    logic [TpsW-1:0] tps;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    m_block_en  = 1'b1;
    m_comp_en   = 1'b1;
    m_max_exp   = 24'd9900;
    m_period    = 16'd60000;
    m_tps       = 26'd187500;
    st_init     = 1'b0;
    st_comp     = 1'b0;
    st_exposing = 1'b0;
    st_image    = '0;
    st_delay    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    queue_event(CMD_TIMER, 1'b1, '0, 1'b0);
    queue_event(CMD_INIT_REQ, 1'b0, '0, 1'b0);
    queue_event(CMD_INIT_MSG, 1'b0, '0, 1'b1);
    queue_event(CMD_INIT_REQ, 1'b1, '0, 1'b1);
    queue_event(CMD_TIMER, 1'b0, 24'hFFFFFF, 1'b1);
    queue_event(CMD_TIMER, 1'b1, '0, 1'b0);
    queue_event(CMD_EXP_END, 1'b0, '0, 1'b0);
    queue_event(CMD_EXP_END, 1'b0, 24'hFFFFFF, 1'b0);
    queue_event(CMD_EXP_END, 1'b0, 24'd9899, 1'b0);
    queue_event(CMD_TIMER, 1'b1, '0, 1'b0);
    queue_event(CMD_TIMER, 1'b1, '0, 1'b0);
    queue_event(CMD_EXP_END, 1'b1, 24'd1, 1'b1);
    queue_event(CMD_TIMER, 1'b1, '0, 1'b0);
    queue_event(CMD_TIMER, 1'b1, '0, 1'b0);
    queue_event(CMD_EXP_END, 1'b0, 24'd9900, 1'b0);
    queue_event(CMD_INIT_MSG, 1'b0, '0, 1'b0);
    wait_until_idle();

    apply_setting(1'b0, 1'b1, 24'd9900, 16'd60000, 26'd187500);
    queue_event(CMD_INIT_REQ, 1'b0, '0, 1'b0);
    queue_event(CMD_EXP_END, 1'b0, 24'd500, 1'b0);
    wait_until_idle();

    apply_setting(1'b1, 1'b0, 24'd9900, 16'd0, 26'd187500);
    queue_event(CMD_INIT_MSG, 1'b0, '0, 1'b1);
    queue_event(CMD_EXP_END, 1'b0, 24'd500, 1'b0);
    queue_event(CMD_TIMER, 1'b1, '0, 1'b0);
    wait_until_idle();

    // delay saturates, compare subtraction floors at zero
    apply_setting(1'b1, 1'b1, 24'hFFFFFF, 16'd100, 26'd48000000);
    queue_event(CMD_EXP_END, 1'b0, 24'hFFFFFE, 1'b0);
    queue_event(CMD_TIMER, 1'b1, '0, 1'b0);
    queue_event(CMD_TIMER, 1'b1, '0, 1'b0);
    wait_until_idle();

    apply_setting(1'b1, 1'b1, 24'd0, 16'hFFFF, 26'd0);
    queue_event(CMD_EXP_END, 1'b0, 24'd5, 1'b0);
    wait_until_idle();

    for (int ph = 0; ph < 8; ph++) begin
      en   = 1'($urandom_range(0, 7) != 0);
      comp = 1'($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 4))
        0:       max_us = 24'd1;
        1:       max_us = 24'd9900;
        2:       max_us = 24'hFFFFFF;
        default: max_us = ExpW'($urandom_range(2, 24'hFFFFFF));
      endcase
      case ($urandom_range(0, 3))
        0:       period = 16'd0;
        1:       period = 16'hFFFF;
        default: period = CmpW'($urandom());
      endcase
      case ($urandom_range(0, 4))
        0:       tps = 26'd0;
        1:       tps = 26'd48000000;
        2:       tps = 26'd187500;
        default: tps = TpsW'($urandom_range(1, 48000000));
      endcase
      apply_setting(en, comp, max_us, period, tps);
      queue_event(CMD_INIT_MSG, 1'b0, '0, 1'b1);
      count = 1;
      while (count < 100) count += queue_random_sequence();
      wait_until_idle();
    end

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_exposure_compensated_trigger: done, clean");
    end else begin
      $display("tb_exposure_compensated_trigger: done, errors");
    end
    $finish;
  end

endmodule

// ===== exposure_compensated_trigger.f =====
hdl/ect_pkg.sv
hdl/exposure_compensated_trigger.sv
dv/tb_exposure_compensated_trigger.sv
